// ===== rtl/nfa_sim_pkg.sv =====
// Package for the NFA word simulator: command and register codes, FSM states.
// No dependencies; imported by nfa_word_simulator, its checker and its testbench.
package nfa_sim_pkg;

  localparam int unsigned STATE_W = 16;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_W   = 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_START  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_INITIAL = 1'b0,
    CFG_FINAL   = 1'b1
  } cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef logic [STATE_W-1:0] mask_t;

endpackage

// ===== rtl/nfa_sim_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nfa_sim_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nfa_word_simulator.sv =====
// NFA word simulator top level: each input item gets a read-then-modify/write pass
// over the transition RAM; a new item is taken only once that pass has finished.
// The RAM holds one word per symbol with every source state's target row.
// Reset clears per-symbol valid flops, so the table reads as empty at once;
// current set and both masks reset to zero. No clearing pass is needed.
// Depends on nfa_sim_pkg and nfa_sim_ram.
module nfa_word_simulator #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nfa_sim_pkg::CFG_W-1:0]     cfg_idx_i,
  input  logic [nfa_sim_pkg::STATE_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [nfa_sim_pkg::SYM_W-1:0]     symbol_i,
  input  logic [nfa_sim_pkg::IDX_W-1:0]     source_state_i,
  input  logic [nfa_sim_pkg::IDX_W-1:0]     target_state_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nfa_sim_pkg::STATE_W-1:0]   active_states_o,
  output logic                              accepted_o,
  output logic                              changed_o
);
  import nfa_sim_pkg::*;

  localparam int unsigned NUM_ROWS = (NUM_STATES > STATE_W) ? STATE_W : NUM_STATES;
  localparam int unsigned WORD_W   = NUM_ROWS * STATE_W;
  localparam int unsigned AW       = $clog2(NUM_SYMBOLS);
  localparam mask_t       SMASK    = STATE_W'((33'd1 << NUM_ROWS) - 33'd1);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [SYM_W-1:0]  sym_q;
  logic [IDX_W-1:0]  src_q, tgt_q;
  logic              rd_vld_q;
  logic [NUM_SYMBOLS-1:0] row_vld_q;
  mask_t             init_q, final_q, cur_q, cur_d;
  logic              out_valid_q;
  mask_t             out_set_q;
  logic              out_acc_q, out_chg_q;

  logic              in_xfer, out_free, finish;
  logic              sym_ok_in, sym_ok, legal, hit, chg;
  logic [WORD_W-1:0] rdata, word, new_word;
  mask_t             tgt_bit, follow;
  logic              ram_we;

  assign sym_ok_in = {1'b0, symbol_i} < (SYM_W+1)'(NUM_SYMBOLS);
  assign sym_ok    = {1'b0, sym_q} < (SYM_W+1)'(NUM_SYMBOLS);
  assign legal     = sym_ok && ({3'b0, src_q} < (IDX_W+3)'(NUM_STATES))
                     && ({3'b0, tgt_q} < (IDX_W+3)'(NUM_STATES));

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    finish     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_e'(command_i);
      sym_q <= symbol_i;
      src_q <= source_state_i;
      tgt_q <= target_state_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (in_xfer) begin
      rd_vld_q <= sym_ok_in ? row_vld_q[symbol_i[AW-1:0]] : 1'b0;
    end
  end

  nfa_sim_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sym_q[AW-1:0]),
    .wdata_i (new_word),
    .re_i    (in_xfer),
    .raddr_i (symbol_i[AW-1:0]),
    .rdata_o (rdata)
  );

  assign word    = rd_vld_q ? rdata : '0;
  assign tgt_bit = (STATE_W'(1) << tgt_q) & SMASK;

  always_comb begin
    mask_t row;
    new_word = word;
    hit      = 1'b0;
    follow   = '0;
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      row = word[r*STATE_W +: STATE_W];
      if (src_q == IDX_W'(r)) begin
        hit = |(row & tgt_bit);
        new_word[r*STATE_W +: STATE_W] = (cmd_q == CMD_ADD) ? (row | tgt_bit)
                                                             : (row & ~tgt_bit);
      end
      if (cur_q[r]) begin
        follow = follow | row;
      end
    end
  end

  always_comb begin
    chg   = 1'b0;
    cur_d = cur_q;
    case (cmd_q)
      CMD_ADD:    chg   = legal && !hit;
      CMD_REMOVE: chg   = legal && hit;
      CMD_START:  cur_d = init_q & SMASK;
      CMD_READ:   cur_d = sym_ok ? (follow & SMASK) : '0;
      default:    chg   = 1'b0;
    endcase
  end

  assign ram_we = finish && chg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ram_we) begin
      row_vld_q[sym_q[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (finish) begin
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      final_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_INITIAL: init_q  <= cfg_wdata_i;
        CFG_FINAL:   final_q <= cfg_wdata_i;
        default:     init_q  <= init_q;
      endcase
    end
  end

  // result register parts the output channel from the RAM pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_set_q <= cur_d;
      out_acc_q <= |(cur_d & final_q & SMASK);
      out_chg_q <= chg;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign active_states_o = out_set_q;
  assign accepted_o      = out_acc_q;
  assign changed_o       = out_chg_q;

`ifndef SYNTHESIS
  a_xfer_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_EXEC)
    else $error("input transfer did not start a table pass");

  a_we_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EXEC && (cmd_q == CMD_ADD || cmd_q == CMD_REMOVE)))
    else $error("table write outside an add or remove pass");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_xfer)
    else $error("table read overlaps write-back");

  a_set_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_states_o & ~SMASK) == '0)
    else $error("active set holds a state out of range");

  a_edit_keeps_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (cmd_q == CMD_ADD || cmd_q == CMD_REMOVE)) |=> $stable(cur_q))
    else $error("add or remove altered the active set");
`endif

endmodule

// ===== bench/nfa_word_simulator_checker.sv =====
// Result checker for nfa_word_simulator: watches register writes and both channels,
// keeps its own copy of the transition table and active set, and compares every result.
// Depends on nfa_sim_pkg.
module nfa_word_simulator_checker
  import nfa_sim_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_idx_i,
  input  mask_t               cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          command_i,
  input  logic [SYM_W-1:0]    symbol_i,
  input  logic [IDX_W-1:0]    source_state_i,
  input  logic [IDX_W-1:0]    target_state_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mask_t               active_states_i,
  input  logic                accepted_i,
  input  logic                changed_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mask_t active_set;
    logic  accepted;
    logic  changed;
  } nfa_result_t;

  mask_t       trans_rows [0:255][0:15];
  mask_t       active_set;
  mask_t       initial_set;
  mask_t       accepting_set;
  nfa_result_t expected_results [$];
  int          mismatch_cnt;
  int          compared_cnt;

  task automatic step_automaton(input cmd_e cmd, input logic [SYM_W-1:0] sym,
                                input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst,
                                output nfa_result_t res);
    mask_t target_bit;
    mask_t next_set;
    target_bit  = mask_t'(1) << dst;
    res.changed = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if ((trans_rows[sym][src] & target_bit) == '0) begin
          trans_rows[sym][src] |= target_bit;
          res.changed = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if ((trans_rows[sym][src] & target_bit) != '0) begin
          trans_rows[sym][src] &= ~target_bit;
          res.changed = 1'b1;
        end
      end
      CMD_START: active_set = initial_set;
      default: begin
        next_set = '0;
        for (int s = 0; s < 16; s++) begin
          if (active_set[s]) next_set |= trans_rows[sym][s];
        end
        active_set = next_set;
      end
    endcase
    res.active_set = active_set;
    res.accepted   = |(active_set & accepting_set);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nfa_result_t want;
    nfa_result_t got;
    if (!rst_ni) begin
      for (int y = 0; y < 256; y++) begin
        for (int s = 0; s < 16; s++) trans_rows[y][s] = '0;
      end
      active_set    = '0;
      initial_set   = '0;
      accepting_set = '0;
      expected_results.delete();
      mismatch_cnt  = 0;
      compared_cnt  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{active_states_i, accepted_i, changed_i};
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: result transfer with nothing outstanding: active=%h acc=%b chg=%b",
                     $realtime, got.active_set, got.accepted, got.changed);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          compared_cnt++;
          if (got !== want) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch: expected active=%h acc=%b chg=%b, got active=%h acc=%b chg=%b",
                       $realtime, want.active_set, want.accepted, want.changed,
                       got.active_set, got.accepted, got.changed);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_INITIAL: initial_set   = cfg_wdata_i;
          CFG_FINAL:   accepting_set = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        step_automaton(cmd_e'(command_i), symbol_i, source_state_i, target_state_i, want);
        expected_results.insert(expected_results.size(), want);
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= expected_results.size();
    compared_o   <= compared_cnt;
  end

endmodule

// ===== bench/nfa_word_simulator_tb.sv =====
// Top of the nfa_word_simulator testbench: clock, reset, register writes, bursty
// command stimulus and random output stalls; verdict from nfa_word_simulator_checker.
// Depends on nfa_sim_pkg, nfa_word_simulator and nfa_word_simulator_checker.
module nfa_word_simulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nfa_sim_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we       = 1'b0;
  cfg_e             cfg_idx      = CFG_INITIAL;
  mask_t            cfg_wdata    = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  cmd_e             command      = CMD_ADD;
  logic [SYM_W-1:0] symbol       = '0;
  logic [IDX_W-1:0] source_state = '0;
  logic [IDX_W-1:0] target_state = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  mask_t            active_states;
  logic             accepted;
  logic             changed;

  int mismatches;
  int pending;
  int compared;
  int burst_left  = 0;
  int reg_writes  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int stall_mode  = 0;
  int cmd_seen [4] = '{0, 0, 0, 0};

  always #10 clk_i = ~clk_i;

  nfa_word_simulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .symbol_i       (symbol),
    .source_state_i (source_state),
    .target_state_i (target_state),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .active_states_o(active_states),
    .accepted_o     (accepted),
    .changed_o      (changed)
  );

  nfa_word_simulator_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .symbol_i       (symbol),
    .source_state_i (source_state),
    .target_state_i (target_state),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .active_states_i(active_states),
    .accepted_i     (accepted),
    .changed_i      (changed),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .compared_o     (compared)
  );

  // receiver: free-running, mostly-ready, mostly-stalled and fully-stalled stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(5, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    symbol       <= sym;
    source_state <= src;
    target_state <= dst;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    cmd_seen[cmd]++;
  endtask

  // hold off the sender until every outstanding result has been transferred
  task automatic drain_results(input int settle_cycles);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input mask_t value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  initial begin
    logic [SYM_W-1:0] pool [4];
    mask_t            init_v;
    mask_t            fin_v;
    int               pick;
    int               total_errors;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_INITIAL, 16'h8001);
    write_reg(CFG_FINAL, 16'h8000);
    send_item(CMD_START,  8'h00, 4'd0,  4'd0);
    send_item(CMD_READ,   8'h00, 4'd0,  4'd0);
    send_item(CMD_ADD,    8'h00, 4'd0,  4'd15);
    send_item(CMD_ADD,    8'h00, 4'd0,  4'd15);
    send_item(CMD_ADD,    8'hFF, 4'd15, 4'd0);
    send_item(CMD_ADD,    8'hFF, 4'd15, 4'd15);
    send_item(CMD_REMOVE, 8'h80, 4'd7,  4'd7);
    send_item(CMD_START,  8'hFF, 4'd15, 4'd15);
    send_item(CMD_READ,   8'h00, 4'd15, 4'd15);
    send_item(CMD_READ,   8'hFF, 4'd0,  4'd0);
    send_item(CMD_READ,   8'hFF, 4'd0,  4'd0);
    send_item(CMD_READ,   8'h00, 4'd0,  4'd0);
    send_item(CMD_REMOVE, 8'hFF, 4'd15, 4'd15);
    send_item(CMD_REMOVE, 8'hFF, 4'd15, 4'd15);
    send_item(CMD_START,  8'h00, 4'd0,  4'd0);
    send_item(CMD_READ,   8'hFF, 4'd0,  4'd0);
    send_item(CMD_READ,   8'h55, 4'd0,  4'd0);
    send_item(CMD_ADD,    8'hAA, 4'd10, 4'd5);
    send_item(CMD_ADD,    8'h55, 4'd5,  4'd10);
    drain_results(4);
    write_reg(CFG_INITIAL, 16'hFFFF);
    write_reg(CFG_FINAL, 16'h0000);
    send_item(CMD_START,  8'h00, 4'd0,  4'd0);
    send_item(CMD_READ,   8'hAA, 4'd0,  4'd0);
    send_item(CMD_READ,   8'h55, 4'd0,  4'd0);
    send_item(CMD_READ,   8'hAA, 4'd0,  4'd0);
    send_item(CMD_ADD,    8'h00, 4'd0,  4'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results(4);
      case (phase)
        0:       begin init_v = 16'h0000; fin_v = 16'hFFFF; end
        1:       begin init_v = 16'hFFFF; fin_v = 16'h0000; end
        2:       begin init_v = 16'hFFFF; fin_v = 16'hFFFF; end
        3:       begin init_v = 16'h0001; fin_v = 16'h8000; end
        4:       begin init_v = 16'h8000; fin_v = 16'h0001; end
        default: begin init_v = mask_t'($urandom); fin_v = mask_t'($urandom); end
      endcase
      write_reg(CFG_INITIAL, init_v);
      write_reg(CFG_FINAL, fin_v);
      // small alphabet per phase so words walk through a well-populated table
      pool[0] = phase[0] ? 8'hFF : 8'h00;
      for (int k = 1; k < 4; k++) pool[k] = SYM_W'($urandom_range(0, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) drain_results(0);
        pick = $urandom_range(0, 99);
        if (pick < 14)
          send_item(CMD_ADD, pool[$urandom_range(0, 3)], IDX_W'($urandom), IDX_W'($urandom));
        else if (pick < 24)
          send_item(CMD_REMOVE, pool[$urandom_range(0, 3)], IDX_W'($urandom),
                    IDX_W'($urandom));
        else if (pick < 34)
          send_item(CMD_START, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        else if (pick < 86)
          send_item(CMD_READ, pool[$urandom_range(0, 3)], IDX_W'($urandom), IDX_W'($urandom));
        else
          send_item(cmd_e'($urandom_range(0, 3)), SYM_W'($urandom), IDX_W'($urandom),
                    IDX_W'($urandom));
      end
    end

    drain_results(10);
    total_errors = mismatches + pending;
    $display("Sent %0d adds, %0d removes, %0d starts, %0d reads over %0d register writes",
             cmd_seen[CMD_ADD], cmd_seen[CMD_REMOVE], cmd_seen[CMD_START],
             cmd_seen[CMD_READ], reg_writes);
    $display("Compared %0d results, %0d mismatched, %0d never arrived",
             compared, mismatches, pending);
    if (total_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nfa_sim_pkg.sv
rtl/nfa_sim_ram.sv
rtl/nfa_word_simulator.sv
bench/nfa_word_simulator_checker.sv
bench/nfa_word_simulator_tb.sv
